// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define WSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define WSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wse_pkg.sv =====
`default_nettype none

package wse_pkg;

  // shared multiplier geometry
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 20;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // configuration register indexes
  localparam logic [1:0] CFG_PULSE_SCALE  = 2'd0;
  localparam logic [1:0] CFG_BODY_RADIUS  = 2'd1;
  localparam logic [1:0] CFG_SPEED_TARGET = 2'd2;

  // configuration reset values
  localparam logic [15:0] PULSE_SCALE_RST  = 16'd256;
  localparam logic [15:0] BODY_RADIUS_RST  = 16'd2560;
  localparam logic [8:0]  SPEED_TARGET_RST = 9'd200;

  // speed limits
  localparam logic [8:0] SPEED_MAX = 9'd500;
  localparam logic [8:0] MIN_LOW   = 9'd10;
  localparam logic [8:0] MIN_HIGH  = 9'd290;

  // arithmetic constants
  localparam logic [6:0]  PULSE_GAIN     = 7'd100;
  localparam logic [18:0] DEG_TO_RAD_Q24 = 19'd292818;
  localparam logic [15:0] TENTH_RECIP    = 16'd52429;
  localparam int          TENTH_SHIFT    = 19;

  // multiplier operand choice
  typedef enum logic [2:0] {
    MS_RSCALE = 3'd0,
    MS_HUNDRED = 3'd1,
    MS_LSCALE = 3'd2,
    MS_RADYAW = 3'd3,
    MS_DEGRAD = 3'd4,
    MS_TENTH = 3'd5
  } mul_sel_e;

  // sequencer states
  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_RSCALE  = 10'b0000000010,
    ST_RHUND   = 10'b0000000100,
    ST_LSCALE  = 10'b0000001000,
    ST_LHUND   = 10'b0000010000,
    ST_RADYAW  = 10'b0000100000,
    ST_DEGRAD  = 10'b0001000000,
    ST_FUSE    = 10'b0010000000,
    ST_TENTH   = 10'b0100000000,
    ST_DONE    = 10'b1000000000
  } seq_state_e;

  // sequencer to datapath controls
  typedef struct packed {
    logic     idle;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     ld_right;
    logic     ld_left;
    logic     ld_fused;
    logic     commit;
  } seq_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/wheel_speed_estimator_unit.sv =====
`default_nettype none

// Wheel speed estimator. An item is taken only while the unit is idle and
// its result lands in the output register at the commit step; the next
// item is taken in the cycle after that, so a new item is never taken
// before the last one is through. Items are paced by the single registered
// multiplier, which the sequencer uses seven times per item (pulse scaling
// and the times-100 step for each wheel, the two yaw compensation products
// and the divide by ten of the smoothed speed), plus one step for the fused
// speed limit and one to commit. If the previous result has not been taken
// the unit holds in its last step until it is. Configuration writes are
// always taken and should only be made while the unit is idle.
module wheel_speed_estimator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] right_pulses_i,
  input  wire logic        right_reverse_i,
  input  wire logic [15:0] left_pulses_i,
  input  wire logic        left_forward_i,
  input  wire logic signed [11:0] yaw_rate_i,
  input  wire logic        exit_tracking_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [8:0]       right_speed_o,
  output logic [8:0]       left_speed_o,
  output logic [8:0]       fused_speed_o,
  output logic [8:0]       smoothed_min_speed_o,
  output logic [1:0]       gain_set_o,
  output logic [31:0]      run_distance_o,
  output logic [31:0]      exit_distance_o
);
  import wse_pkg::*;

  seq_ctrl_t ctrl;

  logic        in_acc;
  logic        out_free;

  logic [15:0] scale_q;
  logic [15:0] radius_q;
  logic [8:0]  target_q;

  logic [15:0] rp_q;
  logic        rneg_q;
  logic [15:0] lp_q;
  logic        lneg_q;
  logic signed [11:0] yaw_q;
  logic        exit_q;

  logic [8:0]  right_t_q;
  logic [8:0]  left_t_q;
  logic [8:0]  fused_t_q;

  logic [8:0]  right_q, left_q, fused_q, min_q;
  logic [1:0]  gain_q;
  logic [31:0] run_q, exit_sum_q;
  logic        out_valid_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  logic [8:0]  wheel_new;
  logic [8:0]  fused_new;
  logic [8:0]  min_new;
  logic [1:0]  gain_new;
  logic [12:0] min_mix;

  // wheel slew limit and clamp
  function automatic logic [8:0] wheel_limit(input logic [30:0] mag, input logic neg,
                                             input logic [8:0] last);
    logic signed [33:0] raw;
    logic signed [33:0] lst;
    logic signed [33:0] diff;
    logic signed [33:0] v;
    logic [8:0]         res;
    raw  = neg ? -$signed({3'b0, mag}) : $signed({3'b0, mag});
    lst  = $signed({25'b0, last});
    diff = raw - lst;
    priority if (diff > 34'sd100) v = lst + 34'sd100;
    else if (diff < -34'sd100)    v = lst - 34'sd100;
    else                          v = raw;
    priority if (v < 34'sd0)                    res = '0;
    else if (v > $signed({25'b0, SPEED_MAX}))   res = SPEED_MAX;
    else                                        res = v[8:0];
    return res;
  endfunction

  assign in_acc      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign in_ready_o  = ctrl.idle;
  assign cfg_ready_o = 1'b1;

  // sequencer
  wse_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_valid_i),
    .out_free_i(out_free),
    .ctrl_o    (ctrl)
  );

  // shared multiplier operand selection
  always_comb begin
    unique case (ctrl.mul_sel)
      MS_RSCALE: begin
        mul_a = $signed({17'b0, rp_q});
        mul_b = $signed({4'b0, scale_q});
      end
      MS_HUNDRED: begin
        mul_a = $signed({1'b0, mul_p[31:0]});
        mul_b = $signed({13'b0, PULSE_GAIN});
      end
      MS_LSCALE: begin
        mul_a = $signed({17'b0, lp_q});
        mul_b = $signed({4'b0, scale_q});
      end
      MS_RADYAW: begin
        mul_a = $signed({17'b0, radius_q});
        mul_b = $signed({{8{yaw_q[11]}}, yaw_q});
      end
      MS_DEGRAD: begin
        mul_a = $signed({{5{mul_p[27]}}, mul_p[27:0]});
        mul_b = $signed({1'b0, DEG_TO_RAD_Q24});
      end
      MS_TENTH: begin
        mul_a = $signed({20'b0, min_mix});
        mul_b = $signed({4'b0, TENTH_RECIP});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  wse_mul u_mul (
    .clk_i(clk_i),
    .en_i (ctrl.mul_en),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  // wheel speed from the scaled pulse count
  always_comb begin
    if (ctrl.ld_right) begin
      wheel_new = wheel_limit(mul_p[38:8], rneg_q, right_q);
    end else begin
      wheel_new = wheel_limit(mul_p[38:8], lneg_q, left_q);
    end
  end

  // yaw compensated fused speed, Q32 candidate against the last value
  always_comb begin
    logic signed [46:0] term;
    logic signed [49:0] cand;
    logic signed [49:0] lastq;
    logic signed [50:0] diff;
    logic signed [50:0] slew;
    logic [9:0]         pair_sum;
    logic signed [18:0] fv;
    term     = $signed(mul_p[46:0]);
    pair_sum = {1'b0, right_t_q} + {1'b0, left_t_q};
    priority if (yaw_q > 12'sd50) begin
      cand = $signed({9'b0, right_t_q, 32'b0}) - $signed({{3{term[46]}}, term});
    end else if (yaw_q < -12'sd50) begin
      cand = $signed({9'b0, left_t_q, 32'b0}) + $signed({{3{term[46]}}, term});
    end else begin
      cand = $signed({9'b0, pair_sum[9:1], 32'b0});
    end
    lastq = $signed({9'b0, fused_q, 32'b0});
    diff  = $signed({cand[49], cand}) - $signed({1'b0, lastq});
    slew  = $signed({19'd100, 32'b0});
    priority if (diff > slew)   fv = $signed({10'b0, fused_q}) + 19'sd100;
    else if (diff < -slew)      fv = $signed({10'b0, fused_q}) - 19'sd100;
    else if (cand < 50'sd0)     fv = -19'sd1;
    else                        fv = $signed({1'b0, cand[49:32]});
    priority if (fv < 19'sd0)                       fused_new = '0;
    else if (fv > $signed({10'b0, SPEED_MAX}))      fused_new = SPEED_MAX;
    else                                            fused_new = fv[8:0];
  end

  // smoothed minimum: old plus nine times fused, divided by ten
  assign min_mix = {4'b0, min_q} + {1'b0, fused_t_q, 3'b0} + {4'b0, fused_t_q};

  // clamp of the smoothed minimum and gain set choice
  always_comb begin
    logic [8:0]  m_raw;
    logic [12:0] m10;
    logic [12:0] t3;
    logic [12:0] t7;
    m_raw = mul_p[TENTH_SHIFT+8:TENTH_SHIFT];
    priority if (m_raw < MIN_LOW) min_new = MIN_LOW;
    else if (m_raw > MIN_HIGH)    min_new = MIN_HIGH;
    else                          min_new = m_raw;
    m10 = ({4'b0, min_new} << 3) + ({4'b0, min_new} << 1);
    t3  = {4'b0, target_q} + ({4'b0, target_q} << 1);
    t7  = ({4'b0, target_q} << 3) - {4'b0, target_q};
    priority if (m10 <= t3)        gain_new = 2'd0;
    else if (m10 <= t7)            gain_new = 2'd1;
    else if (min_new <= target_q)  gain_new = 2'd2;
    else                           gain_new = 2'd3;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= PULSE_SCALE_RST;
      radius_q <= BODY_RADIUS_RST;
      target_q <= SPEED_TARGET_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PULSE_SCALE:  scale_q  <= cfg_data_i;
        CFG_BODY_RADIUS:  radius_q <= cfg_data_i;
        CFG_SPEED_TARGET: target_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // input item capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rp_q   <= right_pulses_i;
      rneg_q <= right_reverse_i;
      lp_q   <= left_pulses_i;
      lneg_q <= ~left_forward_i;
      yaw_q  <= yaw_rate_i;
      exit_q <= exit_tracking_i;
    end
  end

  // per item intermediate speeds
  always_ff @(posedge clk_i) begin
    if (ctrl.ld_right) right_t_q <= wheel_new;
    if (ctrl.ld_left)  left_t_q  <= wheel_new;
    if (ctrl.ld_fused) fused_t_q <= fused_new;
  end

  // estimator state, which is also the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q    <= '0;
      left_q     <= '0;
      fused_q    <= '0;
      min_q      <= MIN_LOW;
      gain_q     <= '0;
      run_q      <= '0;
      exit_sum_q <= '0;
    end else if (ctrl.commit) begin
      right_q <= right_t_q;
      left_q  <= left_t_q;
      fused_q <= fused_t_q;
      min_q   <= min_new;
      gain_q  <= gain_new;
      run_q   <= run_q + {23'b0, fused_t_q};
      if (exit_q) exit_sum_q <= exit_sum_q + {23'b0, fused_t_q};
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign right_speed_o        = right_q;
  assign left_speed_o         = left_q;
  assign fused_speed_o        = fused_q;
  assign smoothed_min_speed_o = min_q;
  assign gain_set_o           = gain_q;
  assign run_distance_o       = run_q;
  assign exit_distance_o      = exit_sum_q;

endmodule

`default_nettype wire

// ===== sv/wse_mul.sv =====
`default_nettype none

module wse_mul (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic signed [wse_pkg::MUL_A_W-1:0] a_i,
  input  wire logic signed [wse_pkg::MUL_B_W-1:0] b_i,
  output logic signed      [wse_pkg::MUL_P_W-1:0] p_o
);
  import wse_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;

  // registered signed product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== sv/wse_seq.sv =====
`default_nettype none

module wse_seq (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        out_free_i,
  output wse_pkg::seq_ctrl_t ctrl_o
);
  import wse_pkg::*;

  seq_state_e state_q, state_d;

  // next state and step controls
  always_comb begin
    state_d         = state_q;
    ctrl_o          = '0;
    ctrl_o.mul_sel  = MS_RSCALE;
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.idle = 1'b1;
        if (start_i) state_d = ST_RSCALE;
      end
      ST_RSCALE: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_RSCALE;
        state_d        = ST_RHUND;
      end
      ST_RHUND: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_HUNDRED;
        state_d        = ST_LSCALE;
      end
      ST_LSCALE: begin
        ctrl_o.ld_right = 1'b1;
        ctrl_o.mul_en   = 1'b1;
        ctrl_o.mul_sel  = MS_LSCALE;
        state_d         = ST_LHUND;
      end
      ST_LHUND: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_HUNDRED;
        state_d        = ST_RADYAW;
      end
      ST_RADYAW: begin
        ctrl_o.ld_left = 1'b1;
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_RADYAW;
        state_d        = ST_DEGRAD;
      end
      ST_DEGRAD: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_DEGRAD;
        state_d        = ST_FUSE;
      end
      ST_FUSE: begin
        ctrl_o.ld_fused = 1'b1;
        state_d         = ST_TENTH;
      end
      ST_TENTH: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_TENTH;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          ctrl_o.commit = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wse_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module wse_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [8:0] right_speed_o,
  input wire logic [8:0] left_speed_o,
  input wire logic [8:0] fused_speed_o,
  input wire logic [8:0] smoothed_min_speed_o
);
  import wse_pkg::*;

  // a waiting result holds
  `WSE_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(fused_speed_o) && $stable(smoothed_min_speed_o), "result changed while stalled")

  // speeds stay within the clamp range
  `WSE_ASSERT_IMP(a_speed_range, out_valid_o, right_speed_o <= SPEED_MAX && left_speed_o <= SPEED_MAX && fused_speed_o <= SPEED_MAX, "speed above limit")

  // smoothed minimum stays within its clamp range
  `WSE_ASSERT_IMP(a_min_range, out_valid_o, smoothed_min_speed_o >= MIN_LOW && smoothed_min_speed_o <= MIN_HIGH, "smoothed minimum out of range")

  // an accepted item keeps the unit busy
  `WSE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")

endmodule

bind wheel_speed_estimator_unit wse_checker u_wse_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_valid_i),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .right_speed_o       (right_speed_o),
  .left_speed_o        (left_speed_o),
  .fused_speed_o       (fused_speed_o),
  .smoothed_min_speed_o(smoothed_min_speed_o)
);

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  import wse_pkg::*;

  // predictor constants
  localparam longint HUNDRED         = 100;
  localparam longint SLEW            = 100;
  localparam longint SPEED_CAP       = 500;
  localparam longint YAW_BAND        = 50;
  localparam longint MIN_FLOOR       = 10;
  localparam longint MIN_CEIL        = 290;
  localparam longint RAD_PER_DEG_Q24 = 292818;
  localparam longint ONE_Q32         = 64'sd4294967296;

  // gain set codes
  localparam logic [1:0] GAIN_SLOW = 2'd0;
  localparam logic [1:0] GAIN_MID  = 2'd1;
  localparam logic [1:0] GAIN_NEAR = 2'd2;
  localparam logic [1:0] GAIN_OVER = 2'd3;

  // register index with no register behind it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [15:0]        r_pulses;
    logic               r_rev;
    logic [15:0]        l_pulses;
    logic               l_fwd;
    logic signed [11:0] yaw;
    logic               exit_trk;
  } tick_t;

  typedef struct {
    logic [8:0]  right_spd;
    logic [8:0]  left_spd;
    logic [8:0]  fused_spd;
    logic [8:0]  min_spd;
    logic [1:0]  gain;
    logic [31:0] run_dist;
    logic [31:0] exit_dist;
  } estimate_t;

  // predicts each tick's estimate and checks the results in order
  class speed_scoreboard;
    longint      scale_q8;
    longint      radius_q8;
    longint      target;
    longint      last_r;
    longint      last_l;
    longint      last_f;
    longint      min_spd;
    logic [31:0] run_sum;
    logic [31:0] exit_sum;
    estimate_t   pending[$];
    int          mismatches;
    int          checked;

    function new();
      scale_q8   = 256;
      radius_q8  = 2560;
      target     = 200;
      last_r     = 0;
      last_l     = 0;
      last_f     = 0;
      min_spd    = MIN_FLOOR;
      run_sum    = '0;
      exit_sum   = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      unique case (idx)
        CFG_PULSE_SCALE:  scale_q8 = data;
        CFG_BODY_RADIUS:  radius_q8 = data;
        CFG_SPEED_TARGET: target = data[8:0];
        default: ;
      endcase
    endfunction

    // scale, direction, slew limit and clamp of one wheel
    function longint wheel(logic [15:0] pulses, logic negate, longint prev);
      longint raw;
      longint v;
      raw = pulses;
      raw = (raw * HUNDRED * scale_q8) >>> 8;
      if (negate) raw = -raw;
      if (raw - prev > SLEW) v = prev + SLEW;
      else if (raw - prev < -SLEW) v = prev - SLEW;
      else v = raw;
      if (v < 0) v = 0;
      if (v > SPEED_CAP) v = SPEED_CAP;
      return v;
    endfunction

    function estimate_t estimate(tick_t t);
      estimate_t e;
      longint r, l, yaw, term, cand, prevq, f, m;
      r = wheel(t.r_pulses, t.r_rev, last_r);
      last_r = r;
      l = wheel(t.l_pulses, !t.l_fwd, last_l);
      last_l = l;
      yaw = t.yaw;
      // yaw compensation term in Q32
      term = radius_q8 * yaw * RAD_PER_DEG_Q24;
      if (yaw > YAW_BAND) cand = r * ONE_Q32 - term;
      else if (yaw < -YAW_BAND) cand = l * ONE_Q32 + term;
      else cand = ((r + l) / 2) * ONE_Q32;
      // fused slew limit at full precision, floor toward minus infinity
      prevq = last_f * ONE_Q32;
      if (cand - prevq > SLEW * ONE_Q32) f = last_f + SLEW;
      else if (cand - prevq < -SLEW * ONE_Q32) f = last_f - SLEW;
      else if (cand < 0) f = -1;
      else f = cand / ONE_Q32;
      if (f < 0) f = 0;
      if (f > SPEED_CAP) f = SPEED_CAP;
      last_f = f;
      run_sum = run_sum + f[31:0];
      if (t.exit_trk) exit_sum = exit_sum + f[31:0];
      // smoothed minimum speed
      m = (min_spd + 9 * f) / 10;
      if (m < MIN_FLOOR) m = MIN_FLOOR;
      if (m > MIN_CEIL) m = MIN_CEIL;
      min_spd = m;
      if (10 * m <= 3 * target) e.gain = GAIN_SLOW;
      else if (10 * m <= 7 * target) e.gain = GAIN_MID;
      else if (m <= target) e.gain = GAIN_NEAR;
      else e.gain = GAIN_OVER;
      e.right_spd = r[8:0];
      e.left_spd  = l[8:0];
      e.fused_spd = f[8:0];
      e.min_spd   = m[8:0];
      e.run_dist  = run_sum;
      e.exit_dist = exit_sum;
      return e;
    endfunction

    function void note_tick(tick_t t);
      pending.push_back(estimate(t));
    endfunction

    function void flag(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("result %0d: %s expected %0d, got %0d", checked, what, want, got);
    endfunction

    function void check_estimate(estimate_t got);
      estimate_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result arrived with no tick pending (fused %0d)", got.fused_spd);
        return;
      end
      want = pending.pop_front();
      if (got.right_spd !== want.right_spd) flag("right_speed", want.right_spd, got.right_spd);
      if (got.left_spd !== want.left_spd) flag("left_speed", want.left_spd, got.left_spd);
      if (got.fused_spd !== want.fused_spd) flag("fused_speed", want.fused_spd, got.fused_spd);
      if (got.min_spd !== want.min_spd) flag("smoothed_min_speed", want.min_spd, got.min_spd);
      if (got.gain !== want.gain) flag("gain_set", want.gain, got.gain);
      if (got.run_dist !== want.run_dist) flag("run_distance", want.run_dist, got.run_dist);
      if (got.exit_dist !== want.exit_dist) flag("exit_distance", want.exit_dist, got.exit_dist);
      checked++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [15:0]        right_pulses_i = '0;
  logic               right_reverse_i = 1'b0;
  logic [15:0]        left_pulses_i = '0;
  logic               left_forward_i = 1'b0;
  logic signed [11:0] yaw_rate_i = '0;
  logic               exit_tracking_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [8:0]         right_speed_o;
  logic [8:0]         left_speed_o;
  logic [8:0]         fused_speed_o;
  logic [8:0]         smoothed_min_speed_o;
  logic [1:0]         gain_set_o;
  logic [31:0]        run_distance_o;
  logic [31:0]        exit_distance_o;

  speed_scoreboard sb = new();

  int send_idle_pct  = 0;
  int sink_stall_pct = 0;
  int hold_asked     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int ticks_taken    = 0;
  int settings_used  = 1;

  wheel_speed_estimator_unit uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .right_pulses_i       (right_pulses_i),
    .right_reverse_i      (right_reverse_i),
    .left_pulses_i        (left_pulses_i),
    .left_forward_i       (left_forward_i),
    .yaw_rate_i           (yaw_rate_i),
    .exit_tracking_i      (exit_tracking_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .right_speed_o        (right_speed_o),
    .left_speed_o         (left_speed_o),
    .fused_speed_o        (fused_speed_o),
    .smoothed_min_speed_o (smoothed_min_speed_o),
    .gain_set_o           (gain_set_o),
    .run_distance_o       (run_distance_o),
    .exit_distance_o      (exit_distance_o)
  );

  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               sb.pending.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // result sink: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_asked != hold_seen) begin
      hold_seen   <= hold_asked;
      hold_left   <= LONG_HOLD;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // watch all three channels; results are checked before a new tick is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (out_valid_o && out_ready_i)
        sb.check_estimate('{right_speed_o, left_speed_o, fused_speed_o,
                            smoothed_min_speed_o, gain_set_o, run_distance_o,
                            exit_distance_o});
      if (in_valid_i && in_ready_o) begin
        ticks_taken++;
        sb.note_tick('{right_pulses_i, right_reverse_i, left_pulses_i,
                       left_forward_i, yaw_rate_i, exit_tracking_i});
      end
    end
  end

  function automatic tick_t mk_tick(logic [15:0] rp, logic rrev, logic [15:0] lp,
                                    logic lfwd, logic signed [11:0] yaw, logic ex);
    tick_t t;
    t = '{rp, rrev, lp, lfwd, yaw, ex};
    return t;
  endfunction

  // mostly small counts so the speeds stay inside the interesting range
  function automatic logic [15:0] pick_pulses();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return 16'($urandom_range(8));
    else if (sel < 80) return 16'($urandom_range(300));
    else return 16'($urandom);
  endfunction

  // offer one item; valid stays high afterward unless the next call idles
  task automatic send_tick(tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    right_pulses_i  <= t.r_pulses;
    right_reverse_i <= t.r_rev;
    left_pulses_i   <= t.l_pulses;
    left_forward_i  <= t.l_fwd;
    yaw_rate_i      <= t.yaw;
    exit_tracking_i <= t.exit_trk;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain(int settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic drive_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_regs(logic [15:0] scale, logic [15:0] radius,
                              logic [15:0] target, bit poke_unused);
    drain(SETTLE);
    drive_reg(CFG_PULSE_SCALE, scale);
    drive_reg(CFG_BODY_RADIUS, radius);
    drive_reg(CFG_SPEED_TARGET, target);
    if (poke_unused) drive_reg(CFG_UNUSED, 16'hA5A5);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  // random ticks under one idling pattern
  task automatic run_phase(int items, int idle_pct, int stall_pct);
    tick_t t;
    int    sel;
    send_idle_pct  = idle_pct;
    sink_stall_pct <= stall_pct;
    repeat (items) begin
      t.r_pulses = pick_pulses();
      t.l_pulses = pick_pulses();
      t.r_rev    = ($urandom_range(99) < 25);
      t.l_fwd    = ($urandom_range(99) >= 25);
      sel = $urandom_range(99);
      if (sel < 40) t.yaw = 12'(int'($urandom_range(120)) - 60);
      else if (sel < 80) t.yaw = 12'(int'($urandom_range(4000)) - 2000);
      else t.yaw = 12'($urandom);
      t.exit_trk = 1'($urandom_range(1));
      send_tick(t);
    end
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed ticks under the reset register values
    send_tick(mk_tick(16'd0, 1'b0, 16'd0, 1'b1, 12'sd0, 1'b0));
    send_tick(mk_tick(16'd5, 1'b0, 16'd5, 1'b1, 12'sd0, 1'b1));
    send_tick(mk_tick(16'd5, 1'b0, 16'd5, 1'b1, 12'sd0, 1'b1));
    send_tick(mk_tick(16'hFFFF, 1'b0, 16'hFFFF, 1'b1, 12'sd0, 1'b1));
    send_tick(mk_tick(16'hFFFF, 1'b0, 16'hFFFF, 1'b1, 12'sd0, 1'b0));
    send_tick(mk_tick(16'hFFFF, 1'b0, 16'hFFFF, 1'b1, 12'sd0, 1'b1));
    send_tick(mk_tick(16'hFFFF, 1'b0, 16'hFFFF, 1'b1, 12'sd0, 1'b1));
    // reversed wheels slew down toward zero
    send_tick(mk_tick(16'd5, 1'b1, 16'd5, 1'b0, 12'sd0, 1'b0));
    send_tick(mk_tick(16'd0, 1'b1, 16'd0, 1'b0, 12'sd0, 1'b1));
    // yaw extremes and the edges of the dead band
    send_tick(mk_tick(16'd3, 1'b0, 16'd3, 1'b1, 12'sd2047, 1'b1));
    send_tick(mk_tick(16'd3, 1'b0, 16'd3, 1'b1, 12'sh800, 1'b1));
    send_tick(mk_tick(16'd4, 1'b0, 16'd1, 1'b1, 12'sd51, 1'b0));
    send_tick(mk_tick(16'd4, 1'b0, 16'd1, 1'b1, 12'sd50, 1'b1));
    send_tick(mk_tick(16'd1, 1'b0, 16'd4, 1'b1, -12'sd50, 1'b1));
    send_tick(mk_tick(16'd1, 1'b0, 16'd4, 1'b1, -12'sd51, 1'b0));
    send_tick(mk_tick(16'd2, 1'b0, 16'd3, 1'b1, 12'sd120, 1'b1));
    send_tick(mk_tick(16'd3, 1'b0, 16'd2, 1'b1, -12'sd120, 1'b1));
    // odd pulse sum, though at the reset scale the speed sum is even
    send_tick(mk_tick(16'd1, 1'b0, 16'd2, 1'b1, 12'sd0, 1'b1));
    // large counts in reverse slew the wheels down toward zero
    send_tick(mk_tick(16'hFFFF, 1'b1, 16'hFFFF, 1'b0, 12'sd0, 1'b1));
    send_tick(mk_tick(16'hFFFF, 1'b1, 16'hFFFF, 1'b0, 12'sd2047, 1'b1));

    // hold results back long enough that the input stalls
    hold_asked <= hold_asked + 1;
    run_phase(12, 0, 0);
    run_phase(138, 0, 0);

    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    run_phase(150, 61, 0);

    program_regs(16'h0000, 16'h0000, 16'h0000, 1'b0);
    run_phase(70, 0, 61);

    program_regs(16'($urandom_range(64, 1024)), 16'($urandom), 16'($urandom_range(511)),
                 1'b0);
    run_phase(180, 36, 36);

    program_regs(16'($urandom_range(128, 512)), 16'($urandom_range(8192)),
                 16'($urandom_range(100, 500)), 1'b0);
    run_phase(150, 0, 0);

    drain(SETTLE);
    $display("covered %0d ticks over %0d register settings, %0d results checked",
             ticks_taken, settings_used, sb.checked);
    $display("sender idle and sink stall phases included one long sink hold-off");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
